// File: design/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants of the swept box collision pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package sbc_pkg;

    localparam int TIME_FRAC_BITS = 16;
    localparam int QUO_W  = TIME_FRAC_BITS + 2;
    localparam int TIME_W = TIME_FRAC_BITS + 3;
    localparam int MAG_W  = 35;
    localparam int NUM_W  = MAG_W + TIME_FRAC_BITS - 1;
    localparam int DEN_W  = 32;
    localparam int SIZE_W = 31;
    localparam int NFACE  = 6;
    localparam logic [QUO_W-1:0] T_CAP = QUO_W'((1 << TIME_FRAC_BITS) + 1);
    localparam logic signed [TIME_W-1:0] T_ONE = TIME_W'(1 << TIME_FRAC_BITS);

    typedef enum logic [2:0] {
        REG_MOVER_SIZE_X    = 3'd0,
        REG_MOVER_SIZE_Y    = 3'd1,
        REG_MOVER_SIZE_Z    = 3'd2,
        REG_OBSTACLE_SIZE_X = 3'd3,
        REG_OBSTACLE_SIZE_Y = 3'd4,
        REG_OBSTACLE_SIZE_Z = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] mover_pos_x;
        logic signed [31:0] mover_pos_y;
        logic signed [31:0] mover_pos_z;
        logic signed [31:0] obstacle_pos_x;
        logic signed [31:0] obstacle_pos_y;
        logic signed [31:0] obstacle_pos_z;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
    } in_t;

    typedef struct packed {
        logic        hit;
        logic [16:0] hit_time;
        logic [1:0]  normal_axis;
        logic        normal_negative;
    } out_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic [DEN_W-1:0] den;
    } face_t;

    typedef struct packed {
        logic       valid;
        logic       undef;
        logic [2:0] mv_neg;
    } side_t;

endpackage
`default_nettype wire

// File: design/sbc_gap.sv
// ----------------------------------------------------------------------------
// sbc_gap
// Input stage: face gaps at twice their value and move magnitudes per axis.
// ----------------------------------------------------------------------------
`default_nettype none
module sbc_gap (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire sbc_pkg::in_t               in_data,
    input  wire logic [3*sbc_pkg::SIZE_W-1:0] mover_size,
    input  wire logic [3*sbc_pkg::SIZE_W-1:0] obstacle_size,
    output sbc_pkg::face_t                  face [sbc_pkg::NFACE],
    output sbc_pkg::side_t                  side
);

    sbc_pkg::face_t face_reg  [sbc_pkg::NFACE];
    sbc_pkg::face_t face_next [sbc_pkg::NFACE];
    sbc_pkg::side_t side_reg, side_next;

    logic signed [31:0] mp [3];
    logic signed [31:0] op [3];
    logic signed [31:0] mv [3];

    assign mp[0] = in_data.mover_pos_x;
    assign mp[1] = in_data.mover_pos_y;
    assign mp[2] = in_data.mover_pos_z;
    assign op[0] = in_data.obstacle_pos_x;
    assign op[1] = in_data.obstacle_pos_y;
    assign op[2] = in_data.obstacle_pos_z;
    assign mv[0] = in_data.move_x;
    assign mv[1] = in_data.move_y;
    assign mv[2] = in_data.move_z;

    always_comb begin
        logic signed [35:0] dist2;
        logic signed [35:0] span;
        logic signed [35:0] g1;
        logic signed [35:0] g2;
        logic               mzero;
        logic [31:0]        den;
        side_next.valid  = in_valid;
        side_next.undef  = 1'b0;
        side_next.mv_neg = '0;
        for (int i = 0; i < 3; i++) begin
            dist2 = (36'(op[i]) - 36'(mp[i])) <<< 1;
            span  = $signed(36'(33'(mover_size[i*sbc_pkg::SIZE_W +: sbc_pkg::SIZE_W])
                    + 33'(obstacle_size[i*sbc_pkg::SIZE_W +: sbc_pkg::SIZE_W])));
            g1    = dist2 - span;
            g2    = dist2 + span;
            mzero = (mv[i] == 32'sd0);
            den   = mv[i][31] ? 32'(-mv[i]) : 32'(mv[i]);
            side_next.mv_neg[i] = mv[i][31];
            if (mzero && (g1 == 36'sd0 || g2 == 36'sd0)) begin
                side_next.undef = 1'b1;
            end
            face_next[2*i].mag   = g1[35] ? sbc_pkg::MAG_W'(-g1) : sbc_pkg::MAG_W'(g1);
            face_next[2*i].neg   = g1[35] ^ (mv[i][31] & !mzero);
            face_next[2*i].den   = den;
            face_next[2*i+1].mag = g2[35] ? sbc_pkg::MAG_W'(-g2) : sbc_pkg::MAG_W'(g2);
            face_next[2*i+1].neg = g2[35] ^ (mv[i][31] & !mzero);
            face_next[2*i+1].den = den;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg.valid <= side_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg.undef  <= side_next.undef;
            side_reg.mv_neg <= side_next.mv_neg;
            face_reg        <= face_next;
        end
    end

    assign face = face_reg;
    assign side = side_reg;

endmodule
`default_nettype wire

// File: design/sbc_div.sv
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined restoring divider, one quotient bit per stage, saturated time.
// ----------------------------------------------------------------------------
`default_nettype none
module sbc_div (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire sbc_pkg::face_t                    face,
    output logic signed [sbc_pkg::TIME_W-1:0]      t
);

    localparam int QB = sbc_pkg::QUO_W;
    localparam int NW = sbc_pkg::NUM_W;

    logic [NW-1:0]             rem_reg [QB];
    logic [QB-1:0]             quo_reg [QB];
    logic [sbc_pkg::DEN_W-1:0] den_reg [QB];
    logic                      neg_reg [QB];
    logic                      sat_reg [QB];
    logic signed [sbc_pkg::TIME_W-1:0] t_reg, t_next;

    logic [NW-1:0]             rem_in [QB];
    logic [QB-1:0]             quo_in [QB];
    logic [sbc_pkg::DEN_W-1:0] den_in [QB];
    logic                      neg_in [QB];
    logic                      sat_in [QB];

    assign rem_in[0] = {face.mag, {(sbc_pkg::TIME_FRAC_BITS-1){1'b0}}};
    assign quo_in[0] = '0;
    assign den_in[0] = face.den;
    assign neg_in[0] = face.neg;
    assign sat_in[0] = (face.den == '0) ||
                       ({1'b0, rem_in[0]} >= ((NW+1)'(face.den) << QB));

    for (genvar k = 1; k < QB; k++) begin : g_link
        assign rem_in[k] = rem_reg[k-1];
        assign quo_in[k] = quo_reg[k-1];
        assign den_in[k] = den_reg[k-1];
        assign neg_in[k] = neg_reg[k-1];
        assign sat_in[k] = sat_reg[k-1];
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [NW:0] dsh;
        logic [NW:0] diff;
        assign dsh  = (NW+1)'(den_in[k]) << (QB-1-k);
        assign diff = {1'b0, rem_in[k]} - dsh;
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= den_in[k];
                neg_reg[k] <= neg_in[k];
                sat_reg[k] <= sat_in[k];
                if (!diff[NW]) begin
                    rem_reg[k] <= diff[NW-1:0];
                    quo_reg[k] <= quo_in[k] | (QB'(1) << (QB-1-k));
                end else begin
                    rem_reg[k] <= rem_in[k];
                    quo_reg[k] <= quo_in[k];
                end
            end
        end
    end

    always_comb begin
        logic [QB-1:0] mag;
        if (sat_reg[QB-1] || quo_reg[QB-1] > sbc_pkg::T_CAP) begin
            mag = sbc_pkg::T_CAP;
        end else begin
            mag = quo_reg[QB-1];
        end
        t_next = neg_reg[QB-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= t_next;
        end
    end

    assign t = t_reg;

endmodule
`default_nettype wire

// File: design/sbc_resolve.sv
// ----------------------------------------------------------------------------
// sbc_resolve
// Output stage: entry and exit bounds, clamp, contact axis, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module sbc_resolve (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic signed [sbc_pkg::TIME_W-1:0] t [sbc_pkg::NFACE],
    input  wire sbc_pkg::side_t                    side,
    output logic                                   out_valid,
    output sbc_pkg::out_t                          out_data
);

    logic          valid_reg;
    sbc_pkg::out_t data_reg, data_next;

    always_comb begin
        logic signed [sbc_pkg::TIME_W-1:0] entry [3];
        logic signed [sbc_pkg::TIME_W-1:0] leave [3];
        logic signed [sbc_pkg::TIME_W-1:0] near_t;
        logic signed [sbc_pkg::TIME_W-1:0] far_t;
        logic                              found;
        for (int i = 0; i < 3; i++) begin
            entry[i] = (t[2*i] < t[2*i+1]) ? t[2*i] : t[2*i+1];
            leave[i] = (t[2*i] < t[2*i+1]) ? t[2*i+1] : t[2*i];
        end
        near_t = '0;
        far_t  = sbc_pkg::T_ONE;
        for (int i = 0; i < 3; i++) begin
            if (entry[i] > near_t) near_t = entry[i];
            if (leave[i] < far_t) far_t = leave[i];
        end
        data_next = '0;
        found     = 1'b0;
        if (!side.undef && near_t < far_t) begin
            for (int i = 0; i < 3; i++) begin
                if (!found && entry[i] == near_t) begin
                    found                     = 1'b1;
                    data_next.hit             = 1'b1;
                    data_next.hit_time        = 17'(near_t);
                    data_next.normal_axis     = 2'(i);
                    data_next.normal_negative = !side.mv_neg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= side.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// File: design/swept_box_collision.sv
// ----------------------------------------------------------------------------
// swept_box_collision
// Swept box against fixed box test, pipelined over six face dividers.
//
//  channel  ports                     beat
//  input    s_valid s_ready s_data    one box pair and move
//  result   m_valid m_ready m_data    hit, time, contact normal
//  config   cfg_valid cfg_ready       cfg_index, cfg_data (size registers)
//
//  One beat enters per cycle unless m_ready stalls the output. Stages:
//  gap stage, 18 divider bit stages, time saturation stage, output stage.
//  Reset clears all valid bits and loads sizes of 1.0; cfg_ready stays high.
//  A stall on m_ready holds every stage; s_ready follows the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module swept_box_collision (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sbc_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sbc_pkg::out_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int QB = sbc_pkg::QUO_W;

    logic [3*sbc_pkg::SIZE_W-1:0] mover_size_reg;
    logic [3*sbc_pkg::SIZE_W-1:0] obstacle_size_reg;
    logic                         en;
    sbc_pkg::face_t               face [sbc_pkg::NFACE];
    sbc_pkg::side_t               side;
    sbc_pkg::side_t               side_reg [QB+1];
    logic signed [sbc_pkg::TIME_W-1:0] t [sbc_pkg::NFACE];

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mover_size_reg    <= {3{sbc_pkg::SIZE_W'(65536)}};
            obstacle_size_reg <= {3{sbc_pkg::SIZE_W'(65536)}};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sbc_pkg::REG_MOVER_SIZE_X:
                    mover_size_reg[0*sbc_pkg::SIZE_W +: sbc_pkg::SIZE_W] <= cfg_data[30:0];
                sbc_pkg::REG_MOVER_SIZE_Y:
                    mover_size_reg[1*sbc_pkg::SIZE_W +: sbc_pkg::SIZE_W] <= cfg_data[30:0];
                sbc_pkg::REG_MOVER_SIZE_Z:
                    mover_size_reg[2*sbc_pkg::SIZE_W +: sbc_pkg::SIZE_W] <= cfg_data[30:0];
                sbc_pkg::REG_OBSTACLE_SIZE_X:
                    obstacle_size_reg[0*sbc_pkg::SIZE_W +: sbc_pkg::SIZE_W] <= cfg_data[30:0];
                sbc_pkg::REG_OBSTACLE_SIZE_Y:
                    obstacle_size_reg[1*sbc_pkg::SIZE_W +: sbc_pkg::SIZE_W] <= cfg_data[30:0];
                sbc_pkg::REG_OBSTACLE_SIZE_Z:
                    obstacle_size_reg[2*sbc_pkg::SIZE_W +: sbc_pkg::SIZE_W] <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    sbc_gap u_gap (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .in_data       (s_data),
        .mover_size    (mover_size_reg),
        .obstacle_size (obstacle_size_reg),
        .face          (face),
        .side          (side)
    );

    for (genvar f = 0; f < sbc_pkg::NFACE; f++) begin : g_div
        sbc_div u_div (
            .aclk (aclk),
            .en   (en),
            .face (face[f]),
            .t    (t[f])
        );
    end

    for (genvar k = 0; k <= QB; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k].valid <= 1'b0;
            end else if (en) begin
                side_reg[k].valid <= (k == 0) ? side.valid : side_reg[(k == 0) ? 0 : k-1].valid;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k].undef  <= (k == 0) ? side.undef : side_reg[(k == 0) ? 0 : k-1].undef;
                side_reg[k].mv_neg <= (k == 0) ? side.mv_neg
                                               : side_reg[(k == 0) ? 0 : k-1].mv_neg;
            end
        end
    end

    sbc_resolve u_resolve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .t         (t),
        .side      (side_reg[QB]),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.hit_time == 17'd0 && m_data.normal_axis == 2'd0
            && !m_data.normal_negative)
        else $error("miss result carries nonzero fields");
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> m_data.hit_time < 17'(sbc_pkg::T_ONE))
        else $error("hit time at or beyond one");
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.normal_axis != 2'd3)
        else $error("contact axis out of range");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result lost under stall");
`endif

endmodule
`default_nettype wire
